// File: rtl/core/ppia_pkg.sv
// Shared types and constants for the parallel port interface adapter.
// Holds the word structs of both channels and the per-port command struct.
// No dependencies.
`default_nettype none

package ppia_pkg;

   // Operation carried by one request word
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_EVENT = 2'd2,
      OP_RESET = 2'd3
   } op_type;

   // Bus addresses
   localparam logic [1:0] ADDR_A_DATA = 2'd0;
   localparam logic [1:0] ADDR_A_CTL  = 2'd1;
   localparam logic [1:0] ADDR_B_DATA = 2'd2;
   localparam logic [1:0] ADDR_B_CTL  = 2'd3;

   // Control line codes
   localparam logic [1:0] LINE_CA1 = 2'd0;
   localparam logic [1:0] LINE_CA2 = 2'd1;
   localparam logic [1:0] LINE_CB1 = 2'd2;
   localparam logic [1:0] LINE_CB2 = 2'd3;

   // Control register fields
   localparam int         SEL_DATA_BIT = 2;
   localparam logic [7:0] FLAG_BIT7    = 8'h80;
   localparam logic [7:0] FLAG_BIT6    = 8'h40;
   localparam logic [7:0] CLR_FLAGS    = 8'h3f;

   typedef struct packed {
      op_type     op;
      logic [1:0] reg_addr;
      logic [7:0] write_data;
      logic [1:0] signal_line;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_out;
      logic       port_a_strobe;
      logic [7:0] port_b_out;
      logic       port_b_strobe;
   } rsp_type;

   // Decoded command for one port
   typedef struct packed {
      logic wr_data;
      logic wr_ctl;
      logic rd_data;
      logic rd_ctl;
      logic set_flag7;
      logic set_flag6;
      logic clear_all;
   } port_cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/parallel_port_interface_adapter_core.sv
// Top level of the two-port parallel interface adapter.
// Input word register, two ppia_port instances, result word register.
// Depends on ppia_pkg and ppia_port.
//
// Usage:
//   req_* carries one word per item: a register write, a register read, a
//   control line event or a soft reset, together with the current pin levels
//   of both ports. rsp_* returns exactly one word per request: the read byte
//   (zero unless a read), the driven value of each port (latch AND direction)
//   and a strobe per port that marks a newly presented output value.
//   Each word sits in the input register while the port logic works on it, and
//   its result is captured in the result register when the word advances.
//   Throughput is one word per cycle while rsp_ready is high; the result
//   register frees itself in the same cycle its word is taken, so there are
//   no bubbles.
//   Reset clears all port registers and both word registers' valid bits.
//   When rsp_ready is low the result word holds, the input word waits in its
//   register, and req_ready drops once both are occupied; nothing is lost.
`default_nettype none

module parallel_port_interface_adapter_core
   import ppia_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   req_type      in_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_type      out_ff, out_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance;
   port_cmd_type cmd_a, cmd_b;
   logic         is_write, is_read, is_event, is_reset;
   logic [7:0]   rd_a, rd_b;
   logic [7:0]   drive_a, drive_b;
   logic         stb_a, stb_b;

   // Move a word forward when the result register is free or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Decode the held request into port commands
   assign is_write = (in_ff.op == OP_WRITE);
   assign is_read  = (in_ff.op == OP_READ);
   assign is_event = (in_ff.op == OP_EVENT);
   assign is_reset = (in_ff.op == OP_RESET);

   always_comb begin
      cmd_a.wr_data   = is_write && (in_ff.reg_addr == ADDR_A_DATA);
      cmd_a.wr_ctl    = is_write && (in_ff.reg_addr == ADDR_A_CTL);
      cmd_a.rd_data   = is_read  && (in_ff.reg_addr == ADDR_A_DATA);
      cmd_a.rd_ctl    = is_read  && (in_ff.reg_addr == ADDR_A_CTL);
      cmd_a.set_flag7 = is_event && (in_ff.signal_line == LINE_CA1);
      cmd_a.set_flag6 = is_event && (in_ff.signal_line == LINE_CA2);
      cmd_a.clear_all = is_reset;
      cmd_b.wr_data   = is_write && (in_ff.reg_addr == ADDR_B_DATA);
      cmd_b.wr_ctl    = is_write && (in_ff.reg_addr == ADDR_B_CTL);
      cmd_b.rd_data   = is_read  && (in_ff.reg_addr == ADDR_B_DATA);
      cmd_b.rd_ctl    = is_read  && (in_ff.reg_addr == ADDR_B_CTL);
      cmd_b.set_flag7 = is_event && (in_ff.signal_line == LINE_CB1);
      cmd_b.set_flag6 = is_event && (in_ff.signal_line == LINE_CB2);
      cmd_b.clear_all = is_reset;
   end

   ppia_port u_port_a (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cmd        (cmd_a),
      .write_data (in_ff.write_data),
      .pins       (in_ff.port_a_pins),
      .read_data  (rd_a),
      .port_out   (drive_a),
      .strobe     (stb_a)
   );

   ppia_port u_port_b (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cmd        (cmd_b),
      .write_data (in_ff.write_data),
      .pins       (in_ff.port_b_pins),
      .read_data  (rd_b),
      .port_out   (drive_b),
      .strobe     (stb_b)
   );

   // Assemble the result word
   always_comb begin
      out_in.read_data     = rd_a | rd_b;
      out_in.port_a_out    = drive_a;
      out_in.port_a_strobe = stb_a;
      out_in.port_b_out    = drive_b;
      out_in.port_b_strobe = stb_b;
   end

   // Next valid bits of both word registers
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture word payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // A held input word is never dropped while the output is stalled
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("input word lost while stalled");

   // A soft reset produces an all-zero result word
   a_reset_zero: assert property (@(posedge clock) disable iff (reset)
      advance && is_reset |=> rsp_valid && (rsp_data == '0))
      else $error("soft reset result not zero");

   // Only reads return a nonzero read byte
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      advance && !is_read |=> rsp_data.read_data == 8'h00)
      else $error("read byte set on non-read word");

   // The port accepts while the result register is empty
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("request stalled with free result register");

endmodule

`default_nettype wire

// File: rtl/core/ppia_port.sv
// One port of the adapter: output latch, direction and control registers.
// Applies a decoded command and returns read byte, driven value and strobe.
// Depends on ppia_pkg.
`default_nettype none

module ppia_port
   import ppia_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire port_cmd_type cmd,
   input  wire logic [7:0]   write_data,
   input  wire logic [7:0]   pins,
   output logic [7:0]        read_data,
   output logic [7:0]        port_out,
   output logic              strobe
);

   logic [7:0] latch_ff, latch_in;
   logic [7:0] dir_ff,   dir_in;
   logic [7:0] ctl_ff,   ctl_in;
   logic       sel_latch;

   assign sel_latch = ctl_ff[SEL_DATA_BIT];

   // Compute next register values and the word fields for this item
   always_comb begin
      latch_in  = latch_ff;
      dir_in    = dir_ff;
      ctl_in    = ctl_ff;
      read_data = 8'h00;
      strobe    = 1'b0;
      if (cmd.clear_all) begin
         latch_in = 8'h00;
         dir_in   = 8'h00;
         ctl_in   = 8'h00;
      end
      if (cmd.wr_data) begin
         if (sel_latch) begin
            latch_in = write_data;
            strobe   = (dir_ff != 8'h00);
         end else begin
            dir_in = write_data;
            strobe = (dir_ff != write_data) && (write_data != 8'h00);
         end
      end
      if (cmd.wr_ctl) begin
         ctl_in = write_data;
      end
      if (cmd.rd_data) begin
         if (sel_latch) begin
            read_data = (latch_ff & dir_ff) | (pins & ~dir_ff);
            ctl_in    = ctl_ff & CLR_FLAGS;
         end else begin
            read_data = dir_ff;
         end
      end
      if (cmd.rd_ctl) begin
         read_data = ctl_ff;
      end
      if (cmd.set_flag7) begin
         ctl_in = ctl_ff | FLAG_BIT7;
      end
      if (cmd.set_flag6) begin
         ctl_in = ctl_ff | FLAG_BIT6;
      end
   end

   assign port_out = latch_in & dir_in;

   // Hold port state, advance it when an item is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= 8'h00;
         dir_ff   <= 8'h00;
         ctl_ff   <= 8'h00;
      end else if (advance) begin
         latch_ff <= latch_in;
         dir_ff   <= dir_in;
         ctl_ff   <= ctl_in;
      end
   end

endmodule

`default_nettype wire
